// ===== rtl/pswrl_pkg.sv =====
// Package with the types, register codes and reset values of the per-source rate limiter.
package pswrl_pkg;

  localparam int DEFAULT_SOURCE_COUNT = 64;

  localparam logic [2:0] CFG_WINDOW_SECONDS        = 3'd0;
  localparam logic [2:0] CFG_DEFAULT_LIMIT         = 3'd1;
  localparam logic [2:0] CFG_FIRST_SPECIAL_SOURCE  = 3'd2;
  localparam logic [2:0] CFG_FIRST_SPECIAL_LIMIT   = 3'd3;
  localparam logic [2:0] CFG_SECOND_SPECIAL_SOURCE = 3'd4;
  localparam logic [2:0] CFG_SECOND_SPECIAL_LIMIT  = 3'd5;

  localparam logic [15:0] RST_WINDOW_SECONDS        = 16'd60;
  localparam logic [7:0]  RST_DEFAULT_LIMIT         = 8'd30;
  localparam logic [7:0]  RST_FIRST_SPECIAL_SOURCE  = 8'd0;
  localparam logic [7:0]  RST_FIRST_SPECIAL_LIMIT   = 8'd60;
  localparam logic [7:0]  RST_SECOND_SPECIAL_SOURCE = 8'd1;
  localparam logic [7:0]  RST_SECOND_SPECIAL_LIMIT  = 8'd30;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0]  source_id;
    logic [15:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic       limited;
    logic       window_closed;
    logic [7:0] dropped_lines;
  } res_t;

  typedef struct packed {
    logic [15:0] window_seconds;
    logic [7:0]  default_limit;
    logic [7:0]  first_special_source;
    logic [7:0]  first_special_limit;
    logic [7:0]  second_special_source;
    logic [7:0]  second_special_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  message_count;
    logic [15:0] window_start;
  } entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

// ===== rtl/pswrl_table.sv =====
// Per-source state memory with registered read and valid bits that reset clears.
module pswrl_table import pswrl_pkg::*; #(
  parameter int SOURCE_COUNT = DEFAULT_SOURCE_COUNT,
  parameter int AW = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t                  mem [SOURCE_COUNT];
  logic [SOURCE_COUNT-1:0] valid;
  entry_t                  rd_entry;
  logic                    rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_valid ? rd_entry : '0;

endmodule

// ===== rtl/pswrl_update.sv =====
// Window check, count update and result computation for one request.
module pswrl_update import pswrl_pkg::*; (
  input  cfg_t   cfg,
  input  req_t   req,
  input  logic   in_range,
  input  entry_t old_entry,
  output entry_t new_entry,
  output res_t   res
);

  logic [15:0] start;
  logic [15:0] elapsed;
  logic [7:0]  count;
  logic [7:0]  limit;
  logic        closed;
  logic        over;

  always_comb begin
    start = (old_entry.window_start == 16'd0) ? req.now_seconds : old_entry.window_start;
    count = (old_entry.message_count == COUNT_MAX) ? COUNT_MAX
                                                   : old_entry.message_count + 8'd1;
    if (req.source_id == cfg.second_special_source) begin
      limit = cfg.second_special_limit;
    end else if (req.source_id == cfg.first_special_source) begin
      limit = cfg.first_special_limit;
    end else begin
      limit = cfg.default_limit;
    end
    elapsed = req.now_seconds - start;
    closed  = (req.now_seconds < start) || (elapsed >= cfg.window_seconds);
    over    = count > limit;
  end

  always_comb begin
    res       = '0;
    new_entry = old_entry;
    if (!in_range) begin
      res.limited = 1'b1;
    end else if (closed) begin
      res.window_closed      = 1'b1;
      res.dropped_lines      = over ? (count - limit) : 8'd0;
      new_entry.message_count = 8'd0;
      new_entry.window_start  = req.now_seconds;
    end else begin
      res.limited             = over;
      new_entry.message_count = count;
      new_entry.window_start  = start;
    end
  end

endmodule

// ===== rtl/per_source_window_rate_limiter_core.sv =====
// Top level of the per-source fixed-window rate limiter.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  req_t (source_id, now_seconds)
//   out      output     out_valid/out_stall  res_t (limited, window_closed, dropped_lines)
//   cfg      input      cfg_write            cfg_index, cfg_data
//
// Each transaction has a table read at acceptance, then the update and write-back in the
// lookup state, which also loads the output register. A new request is not accepted
// until the current one has left the lookup state, as in_stall is high there.
// Reset clears the valid bits of the table; no clearing pass is needed.
// A stalled result holds in the output register and the lookup waits until it frees.
module per_source_window_rate_limiter_core import pswrl_pkg::*; #(
  parameter int SOURCE_COUNT = DEFAULT_SOURCE_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output res_t        out_data,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  req_t   req;
  logic   req_in_range;
  logic   in_accept;
  logic   load;
  logic   in_range_now;
  logic   tbl_rd_en;
  logic   tbl_wr_en;
  entry_t tbl_rd_data;
  entry_t tbl_wr_data;
  res_t   res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_seconds        <= RST_WINDOW_SECONDS;
      cfg.default_limit         <= RST_DEFAULT_LIMIT;
      cfg.first_special_source  <= RST_FIRST_SPECIAL_SOURCE;
      cfg.first_special_limit   <= RST_FIRST_SPECIAL_LIMIT;
      cfg.second_special_source <= RST_SECOND_SPECIAL_SOURCE;
      cfg.second_special_limit  <= RST_SECOND_SPECIAL_LIMIT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WINDOW_SECONDS:        cfg.window_seconds        <= cfg_data;
        CFG_DEFAULT_LIMIT:         cfg.default_limit         <= cfg_data[7:0];
        CFG_FIRST_SPECIAL_SOURCE:  cfg.first_special_source  <= cfg_data[7:0];
        CFG_FIRST_SPECIAL_LIMIT:   cfg.first_special_limit   <= cfg_data[7:0];
        CFG_SECOND_SPECIAL_SOURCE: cfg.second_special_source <= cfg_data[7:0];
        CFG_SECOND_SPECIAL_LIMIT:  cfg.second_special_limit  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign in_accept    = in_valid && !in_stall;
  assign in_range_now = {1'b0, in_data.source_id} < 9'(SOURCE_COUNT);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    load      = 1'b0;
    unique case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_LOOKUP: load     = !out_valid || !out_stall;
      default: begin
      end
    endcase
    tbl_rd_en = in_accept && in_range_now;
    tbl_wr_en = load && req_in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req          <= in_data;
      req_in_range <= in_range_now;
    end
  end

  pswrl_table #(
    .SOURCE_COUNT(SOURCE_COUNT),
    .AW(AW)
  ) u_table (
    .clk(clk),
    .rst(rst),
    .rd_en(tbl_rd_en),
    .rd_addr(in_data.source_id[AW-1:0]),
    .rd_data(tbl_rd_data),
    .wr_en(tbl_wr_en),
    .wr_addr(req.source_id[AW-1:0]),
    .wr_data(tbl_wr_data)
  );

  pswrl_update u_update (
    .cfg(cfg),
    .req(req),
    .in_range(req_in_range),
    .old_entry(tbl_rd_data),
    .new_entry(tbl_wr_data),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  a_close_passes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.limited && out_data.window_closed))
    else $error("A transaction that closed its window was also limited.");

  a_drop_on_close: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.dropped_lines != 8'd0) |-> out_data.window_closed)
    else $error("Dropped lines were reported without a window close.");

  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_LOOKUP))
    else $error("An accepted transaction did not enter the lookup cycle.");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    tbl_wr_en |-> (req_in_range && state == ST_LOOKUP))
    else $error("The table was written outside a lookup of a valid source.");

endmodule

// ===== tb/tb_per_source_window_rate_limiter_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the per-source fixed-window rate limiter core.
module tb_per_source_window_rate_limiter_core;
  import pswrl_pkg::*;

  localparam int SRC_COUNT = DEFAULT_SOURCE_COUNT;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  req_t        in_data;
  logic        out_valid;
  logic        out_stall;
  res_t        out_data;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  logic        rx_hold = 1'b0;
  logic        rx_pause = 1'b0;
  int unsigned hold_len = 0;
  int unsigned rx_wait = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  logic [15:0] traffic_clock = 16'd0;

  logic [15:0] win_len;
  logic [7:0]  def_limit;
  logic [7:0]  spec1_src;
  logic [7:0]  spec1_limit;
  logic [7:0]  spec2_src;
  logic [7:0]  spec2_limit;
  logic [7:0]  msg_count [SRC_COUNT];
  logic [15:0] win_start [SRC_COUNT];
  res_t        pending_decisions [$];

  assign out_stall = rx_hold | rx_pause;

  per_source_window_rate_limiter_core #(
    .SOURCE_COUNT(SRC_COUNT)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_per_source_window_rate_limiter_core failed");
      $finish;
    end
  end

  function automatic res_t predict_decision(input req_t r);
    res_t        res;
    int unsigned src;
    int unsigned stamp;
    int unsigned start;
    int unsigned count;
    int unsigned lim;
    res = '0;
    src = r.source_id;
    stamp = r.now_seconds;
    if (src >= SRC_COUNT) begin
      res.limited = 1'b1;
      return res;
    end
    if (win_start[src] == 16'd0) win_start[src] = r.now_seconds;
    count = msg_count[src];
    if (count < 255) count++;
    msg_count[src] = count[7:0];
    start = win_start[src];
    if (src == spec2_src) lim = spec2_limit;
    else if (src == spec1_src) lim = spec1_limit;
    else lim = def_limit;
    if (stamp < start || stamp - start >= win_len) begin
      win_start[src] = r.now_seconds;
      msg_count[src] = 8'd0;
      res.window_closed = 1'b1;
      if (count > lim) res.dropped_lines = 8'(count - lim);
    end else if (count > lim) begin
      res.limited = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [15:0] next_stamp();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) traffic_clock = traffic_clock + 16'($urandom_range(0, 3));
    else if (pick < 90) traffic_clock = traffic_clock - 16'($urandom_range(1, 50));
    else if (pick < 95) traffic_clock = 16'($urandom);
    else traffic_clock = traffic_clock + 16'($urandom_range(0, 2 * win_len));
    return traffic_clock;
  endfunction

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_decisions.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: limited=%0b closed=%0b dropped=%0d",
                   out_data.limited, out_data.window_closed, out_data.dropped_lines);
      end else begin
        want = pending_decisions.pop_front();
        if (out_data.limited !== want.limited ||
            out_data.window_closed !== want.window_closed ||
            out_data.dropped_lines !== want.dropped_lines) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected limited=%0b closed=%0b dropped=%0d, got %0b %0b %0d",
                     want.limited, want.window_closed, want.dropped_lines,
                     out_data.limited, out_data.window_closed, out_data.dropped_lines);
        end
      end
      rx_wait = rx_gaps ? $urandom_range(0, 6) : 0;
    end
  end

  always @(negedge clk) begin
    if (rx_wait > 0) begin
      rx_pause = 1'b1;
      rx_wait--;
    end else begin
      rx_pause = 1'b0;
    end
  end

  // The long hold-off counts its own cycles, independent of result traffic.
  initial begin
    forever begin
      wait (hold_len != 0);
      @(negedge clk);
      rx_hold = 1'b1;
      repeat (hold_len) @(negedge clk);
      rx_hold = 1'b0;
      hold_len = 0;
    end
  end

  task automatic send_request(input logic [7:0] src, input logic [15:0] stamp);
    int unsigned gap;
    req_t        r;
    gap = tx_gaps ? $urandom_range(0, 6) : 0;
    r.source_id = src;
    r.now_seconds = stamp;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = r;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_decisions.push_back(predict_decision(r));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      CFG_WINDOW_SECONDS:        win_len = val;
      CFG_DEFAULT_LIMIT:         def_limit = val[7:0];
      CFG_FIRST_SPECIAL_SOURCE:  spec1_src = val[7:0];
      CFG_FIRST_SPECIAL_LIMIT:   spec1_limit = val[7:0];
      CFG_SECOND_SPECIAL_SOURCE: spec2_src = val[7:0];
      CFG_SECOND_SPECIAL_LIMIT:  spec2_limit = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [15:0] w, input logic [7:0] dl,
                              input logic [7:0] s1, input logic [7:0] l1,
                              input logic [7:0] s2, input logic [7:0] l2);
    wait_idle();
    write_register(CFG_WINDOW_SECONDS, w);
    write_register(CFG_DEFAULT_LIMIT, {8'd0, dl});
    write_register(CFG_FIRST_SPECIAL_SOURCE, {8'd0, s1});
    write_register(CFG_FIRST_SPECIAL_LIMIT, {8'd0, l1});
    write_register(CFG_SECOND_SPECIAL_SOURCE, {8'd0, s2});
    write_register(CFG_SECOND_SPECIAL_LIMIT, {8'd0, l2});
  endtask

  task automatic test_directed_defaults();
    send_request(8'd2, 16'd100);
    send_request(8'd2, 16'd159);
    send_request(8'd2, 16'd160);
    send_request(8'd2, 16'd50);
    send_request(8'd64, 16'd10);
    send_request(8'd255, 16'hFFFF);
    send_request(8'd63, 16'hFFFF);
    send_request(8'd63, 16'd0);
    send_request(8'd63, 16'd5);
    send_request(8'd0, 16'd7);
    send_request(8'd1, 16'd7);
    send_request(8'h55, 16'hAAAA);
    send_request(8'd42, 16'h5555);
  endtask

  task automatic test_special_sources();
    apply_config(16'hFFFF, 8'd1, 8'd3, 8'd2, 8'd4, 8'd255);
    repeat (4) send_request(8'd3, 16'd10);
    repeat (4) send_request(8'd4, 16'd10);
    repeat (3) send_request(8'd5, 16'd10);
    send_request(8'd3, 16'd5);
    send_request(8'd5, 16'd5);
    apply_config(16'hFFFF, 8'd1, 8'd3, 8'd2, 8'd3, 8'd255);
    repeat (4) send_request(8'd3, 16'd20);
    send_request(8'd3, 16'd6);
  endtask

  task automatic test_count_saturation();
    apply_config(16'hFFFF, 8'd0, 8'd200, 8'd60, 8'd201, 8'd30);
    send_request(8'd5, 16'd1000);
    repeat (270) send_request(8'd5, 16'($urandom_range(1000, 65535)));
    send_request(8'd5, 16'd999);
  endtask

  task automatic test_backpressure();
    apply_config(16'd20, 8'd3, 8'd0, 8'd60, 8'd1, 8'd30);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    @(posedge clk);
    hold_len = 80;
    repeat (30) send_request(8'($urandom_range(0, 7)), next_stamp());
    wait_idle();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    logic [7:0]  src;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: apply_config(16'd1, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0);
        1: apply_config(16'hFFFF, 8'd0, 8'd0, 8'd255, 8'd0, 8'd1);
        default: apply_config(16'($urandom_range(1, 40)), 8'($urandom_range(0, 6)),
                              8'($urandom_range(0, 7)), 8'($urandom_range(0, 6)),
                              8'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      endcase
      tx_gaps = (phase != 2);
      rx_gaps = (phase != 3);
      repeat (200) begin
        pick = $urandom_range(0, 99);
        if (pick < 90) src = 8'($urandom_range(0, 7));
        else if (pick < 95) src = 8'($urandom_range(0, SRC_COUNT - 1));
        else src = 8'($urandom_range(SRC_COUNT, 255));
        send_request(src, next_stamp());
      end
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin : run_tests
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_WINDOW_SECONDS;
    cfg_data = '0;
    win_len = RST_WINDOW_SECONDS;
    def_limit = RST_DEFAULT_LIMIT;
    spec1_src = RST_FIRST_SPECIAL_SOURCE;
    spec1_limit = RST_FIRST_SPECIAL_LIMIT;
    spec2_src = RST_SECOND_SPECIAL_SOURCE;
    spec2_limit = RST_SECOND_SPECIAL_LIMIT;
    for (int i = 0; i < SRC_COUNT; i++) begin
      msg_count[i] = 8'd0;
      win_start[i] = 16'd0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_defaults();
    test_special_sources();
    test_count_saturation();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (20) @(posedge clk);
    if (pending_decisions.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("tb_per_source_window_rate_limiter_core passed");
    end else begin
      $display("tb_per_source_window_rate_limiter_core failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pswrl_pkg.sv
rtl/pswrl_table.sv
rtl/pswrl_update.sv
rtl/per_source_window_rate_limiter_core.sv
tb/tb_per_source_window_rate_limiter_core.sv
